[rtl/gfba_pkg.sv]
// ============================================================================
// gfba_pkg
// shared types and codes of the grouped free block allocator
// ============================================================================
package gfba_pkg;

    // block id width on the request and response channels
    localparam int ID_W = 10;

    // request function codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // response status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // operation chosen by the controller when a request is taken
    typedef logic [2:0] t_op;
    localparam t_op OP_POP    = 3'd0;  // allocate from the stack
    localparam t_op OP_RELOAD = 3'd1;  // allocate the leader, reload its group
    localparam t_op OP_FAIL   = 3'd2;  // allocate with no free block left
    localparam t_op OP_PUSH   = 3'd3;  // free onto the stack
    localparam t_op OP_SAVE   = 3'd4;  // free with full stack, save the group
    localparam t_op OP_IGNORE = 3'd5;  // free of an out of range id

    // controller to datapath commands
    typedef struct packed {
        logic start;     // request taken this cycle
        t_op  op;        // operation of the request taken
        logic copy_rd;   // issue one group copy read
        logic finish;    // close a group reload
        logic load_out;  // move the result into the output register
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic empty;      // stack holds no id
        logic full;       // stack holds GROUP_SIZE - 1 ids, the members of a group
        logic chain_end;  // link marks the end of the chain
        logic id_ok;      // requested id is below the block count
        logic copy_last;  // this copy read is the last of the group
        logic out_free;   // output register can take a result
    } t_sts;

endpackage

[rtl/gfba_req_if.sv]
// ============================================================================
// gfba_req_if
// request channel: function and block id with valid/ready
// ============================================================================
interface gfba_req_if;
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic [gfba_pkg::ID_W-1:0] block_id;

    modport source (output valid, output func, output block_id, input ready);
    modport sink   (input valid, input func, input block_id, output ready);
endinterface

[rtl/gfba_rsp_if.sv]
// ============================================================================
// gfba_rsp_if
// response channel: status and allocated id with valid/ready
// ============================================================================
interface gfba_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      status;
    logic [gfba_pkg::ID_W-1:0] alloc_id;

    modport source (output valid, output status, output alloc_id, input ready);
    modport sink   (input valid, input status, input alloc_id, output ready);
endinterface

[rtl/gfba_ram.sv]
// ============================================================================
// gfba_ram
// simple dual port ram, one write and one registered read per cycle
// ============================================================================
module gfba_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/gfba_ctrl.sv]
// ============================================================================
// gfba_ctrl
// request sequencer: picks the operation and steps group copies
// ============================================================================
module gfba_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  logic           i_func,
    input  gfba_pkg::t_sts i_sts,
    output logic           o_req_ready,
    output gfba_pkg::t_cmd o_cmd
);
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_COPY  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_RESP  = 2'd3;

    logic [1:0]      r_state;
    logic [1:0]      n_state;
    gfba_pkg::t_op   w_op;

    // operation decode from function and stack state
    always_comb begin
        if (i_func == gfba_pkg::FUNC_ALLOC) begin
            if (!i_sts.empty) begin
                w_op = gfba_pkg::OP_POP;
            end else if (i_sts.chain_end) begin
                w_op = gfba_pkg::OP_FAIL;
            end else begin
                w_op = gfba_pkg::OP_RELOAD;
            end
        end else begin
            if (!i_sts.id_ok) begin
                w_op = gfba_pkg::OP_IGNORE;
            end else if (i_sts.full) begin
                w_op = gfba_pkg::OP_SAVE;
            end else begin
                w_op = gfba_pkg::OP_PUSH;
            end
        end
    end

    always_comb begin
        n_state        = r_state;
        o_req_ready    = 1'b0;
        o_cmd          = '0;
        o_cmd.op       = w_op;
        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.start = 1'b1;
                    if (w_op inside {gfba_pkg::OP_RELOAD, gfba_pkg::OP_SAVE}) begin
                        n_state = ST_COPY;
                    end else begin
                        n_state = ST_RESP;
                    end
                end
            end
            ST_COPY: begin
                o_cmd.copy_rd = 1'b1;
                if (i_sts.copy_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_RESP;
            end
            ST_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

[rtl/gfba_dpath.sv]
// ============================================================================
// gfba_dpath
// stack, link and group stores, counters and the output register
// ============================================================================
module gfba_dpath #(
    parameter int NUM_BLOCKS = 1024,
    parameter int GROUP_SIZE = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [gfba_pkg::ID_W-1:0] i_block_id,
    input  gfba_pkg::t_cmd            i_cmd,
    output gfba_pkg::t_sts            o_sts,
    output logic                      o_rsp_valid,
    input  logic                      i_rsp_ready,
    output logic                      o_rsp_status,
    output logic [gfba_pkg::ID_W-1:0] o_rsp_alloc_id
);
    localparam int ID_W     = gfba_pkg::ID_W;
    localparam int STK_D    = GROUP_SIZE - 1;
    localparam int SW       = (STK_D > 1) ? $clog2(STK_D) : 1;
    localparam int CW       = $clog2(STK_D + 1);
    localparam int LW       = $clog2(NUM_BLOCKS + 1);
    // only ids that fit the id field can ever lead a saved group
    localparam int STORE_D  = (NUM_BLOCKS < (1 << ID_W)) ? NUM_BLOCKS : (1 << ID_W);
    localparam int BW       = $clog2(STORE_D);
    localparam int MEM_D    = STORE_D * (1 << SW);

    logic [CW-1:0]    r_count;
    logic [LW-1:0]    r_leader;
    logic [BW-1:0]    r_base;
    logic [SW-1:0]    r_idx;
    logic             r_cp_v;
    logic [SW-1:0]    r_cp_idx;
    logic             r_save;
    logic             r_res_st;
    logic [ID_W-1:0]  r_res_id;
    logic             r_res_stk;
    logic             r_out_v;
    logic             r_out_st;
    logic [ID_W-1:0]  r_out_id;

    logic             w_stk_we;
    logic [SW-1:0]    w_stk_waddr;
    logic [ID_W-1:0]  w_stk_wdata;
    logic             w_stk_re;
    logic [SW-1:0]    w_stk_raddr;
    logic [ID_W-1:0]  w_stk_rdata;
    logic [SW-1:0]    w_pop_addr;
    logic             w_mem_we;
    logic             w_mem_re;
    logic [ID_W-1:0]  w_mem_rdata;
    logic             w_lnk_we;
    logic             w_lnk_re;
    logic [LW-1:0]    w_lnk_rdata;
    logic             w_start_pop;
    logic             w_start_push;
    logic             w_start_save;
    logic             w_start_reload;

    assign w_start_pop    = i_cmd.start && (i_cmd.op == gfba_pkg::OP_POP);
    assign w_start_push   = i_cmd.start && (i_cmd.op == gfba_pkg::OP_PUSH);
    assign w_start_save   = i_cmd.start && (i_cmd.op == gfba_pkg::OP_SAVE);
    assign w_start_reload = i_cmd.start && (i_cmd.op == gfba_pkg::OP_RELOAD);

    assign o_sts.empty     = (r_count == '0);
    assign o_sts.full      = (r_count == CW'(STK_D));
    assign o_sts.chain_end = (32'(r_leader) >= NUM_BLOCKS);
    assign o_sts.id_ok     = (32'(i_block_id) < NUM_BLOCKS);
    assign o_sts.copy_last = (r_idx == SW'(STK_D - 1));
    assign o_sts.out_free  = !r_out_v || i_rsp_ready;

    // free id stack
    assign w_pop_addr  = SW'(r_count - CW'(1));
    assign w_stk_we    = w_start_push || (r_cp_v && !r_save);
    assign w_stk_waddr = r_cp_v ? r_cp_idx : SW'(r_count);
    assign w_stk_wdata = r_cp_v ? w_mem_rdata : i_block_id;
    assign w_stk_re    = w_start_pop || (i_cmd.copy_rd && r_save);
    assign w_stk_raddr = i_cmd.copy_rd ? r_idx : w_pop_addr;

    gfba_ram #(.WIDTH(ID_W), .DEPTH(STK_D)) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_stk_we),
        .i_waddr (w_stk_waddr),
        .i_wdata (w_stk_wdata),
        .i_re    (w_stk_re),
        .i_raddr (w_stk_raddr),
        .o_rdata (w_stk_rdata)
    );

    // saved group members, one row of stack entries per leader
    assign w_mem_we = r_cp_v && r_save;
    assign w_mem_re = i_cmd.copy_rd && !r_save;

    gfba_ram #(.WIDTH(ID_W), .DEPTH(MEM_D)) u_members (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr ({r_base, r_cp_idx}),
        .i_wdata (w_stk_rdata),
        .i_re    (w_mem_re),
        .i_raddr ({r_base, r_idx}),
        .o_rdata (w_mem_rdata)
    );

    // saved link per leader
    assign w_lnk_we = w_start_save;
    assign w_lnk_re = w_start_reload;

    gfba_ram #(.WIDTH(LW), .DEPTH(STORE_D)) u_links (
        .i_clk   (i_clk),
        .i_we    (w_lnk_we),
        .i_waddr (i_block_id[BW-1:0]),
        .i_wdata (r_leader),
        .i_re    (w_lnk_re),
        .i_raddr (r_leader[BW-1:0]),
        .o_rdata (w_lnk_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_leader <= LW'(NUM_BLOCKS);
            r_cp_v   <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_cp_v <= i_cmd.copy_rd;
            if (i_cmd.start) begin
                case (i_cmd.op)
                    gfba_pkg::OP_POP:    r_count <= r_count - CW'(1);
                    gfba_pkg::OP_PUSH:   r_count <= r_count + CW'(1);
                    gfba_pkg::OP_RELOAD: r_count <= CW'(STK_D);
                    gfba_pkg::OP_SAVE: begin
                        r_count  <= '0;
                        r_leader <= LW'(i_block_id);
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.finish && !r_save) begin
                r_leader <= w_lnk_rdata;
            end
            if (i_cmd.load_out) begin
                r_out_v <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // payload and copy bookkeeping
    always_ff @(posedge i_clk) begin
        r_cp_idx <= r_idx;
        if (i_cmd.start) begin
            r_idx     <= '0;
            r_save    <= (i_cmd.op == gfba_pkg::OP_SAVE);
            r_res_stk <= (i_cmd.op == gfba_pkg::OP_POP);
            r_res_st  <= (i_cmd.op == gfba_pkg::OP_FAIL) ? gfba_pkg::STATUS_FAIL
                                                         : gfba_pkg::STATUS_OK;
            r_res_id  <= (i_cmd.op == gfba_pkg::OP_RELOAD) ? ID_W'(r_leader) : '0;
            if (i_cmd.op == gfba_pkg::OP_RELOAD) begin
                r_base <= r_leader[BW-1:0];
            end else if (i_cmd.op == gfba_pkg::OP_SAVE) begin
                r_base <= i_block_id[BW-1:0];
            end
        end else if (i_cmd.copy_rd) begin
            r_idx <= r_idx + SW'(1);
        end
        if (i_cmd.load_out) begin
            r_out_st <= r_res_st;
            r_out_id <= r_res_stk ? w_stk_rdata : r_res_id;
        end
    end

    assign o_rsp_valid    = r_out_v;
    assign o_rsp_status   = r_out_st;
    assign o_rsp_alloc_id = r_out_id;
endmodule

[rtl/grouped_free_block_allocator.sv]
// ============================================================================
// grouped_free_block_allocator
// grouped-link free block manager with an on-chip store of saved groups
// ============================================================================
//
//  channel  dir  fields                 meaning
//  -------  ---  ---------------------  ---------------------------------------
//  i_req    in   func, block_id         allocate (func 0) or free block_id
//  o_rsp    out  status, alloc_id       one response per request
//
//  a pop, push, failed allocate or ignored free is taken in the idle state,
//  then the response state loads the output register once it can take it
//  a group save (free with a full stack) or group reload (allocate with an
//  empty stack) runs the copy state, where the stack ram copies one entry
//  per cycle to or from the group store, then the drain and response states
//  reset clears the stack count and sets the link to end of chain; the
//  stores are not cleared, so there is no sweep after reset
//  a waiting response does not block the next request; the sequencer only
//  stalls in its response cycle while the output register is still full
//
module grouped_free_block_allocator #(
    parameter int NUM_BLOCKS = 1024,
    parameter int GROUP_SIZE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gfba_req_if.sink    i_req,
    gfba_rsp_if.source  o_rsp
);
    gfba_pkg::t_cmd w_cmd;
    gfba_pkg::t_sts w_sts;

    // sequencer: decides the operation of each request and steps copies
    gfba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_func      (i_req.func),
        .i_sts       (w_sts),
        .o_req_ready (i_req.ready),
        .o_cmd       (w_cmd)
    );

    // datapath: stack, group stores, link, counters, output register
    gfba_dpath #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .GROUP_SIZE (GROUP_SIZE)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_block_id     (i_req.block_id),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_rsp_valid    (o_rsp.valid),
        .i_rsp_ready    (o_rsp.ready),
        .o_rsp_status   (o_rsp.status),
        .o_rsp_alloc_id (o_rsp.alloc_id)
    );

    // every request taken starts an operation in the datapath
    a_start_on_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |-> w_cmd.start)
        else $error("request taken without datapath start");

    // the output register is only loaded when it can take a result
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> w_sts.out_free)
        else $error("result loaded over a pending response");

    // no request is taken while a group copy is running
    a_no_req_in_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.copy_rd |-> !i_req.ready)
        else $error("request ready during group copy");

    // a loaded result shows up on the response channel
    a_rsp_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |=> o_rsp.valid)
        else $error("response missing after result load");

endmodule
